// ===== rtl/play_position_time_display_defines.svh =====
// Assertion macros shared by the play position time display RTL.
`ifndef PLAY_POSITION_TIME_DISPLAY_DEFINES_SVH
`define PLAY_POSITION_TIME_DISPLAY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pptd assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define PPTD_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("pptd assertion failed");

`endif

// ===== rtl/pptd_pkg.sv =====
// Shared constants and types of the play position time display.
package pptd_pkg;

    localparam int POSITION_BITS      = 19;
    localparam int INTRO_SECTORS      = 749;
    localparam int NEAR_END           = 20;
    localparam int SECTORS_PER_SECOND = 75;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int REG_ADDR_BITS      = 3;

    typedef enum logic [0:0] {
        REG_TIME_MODE    = 1'b0,
        REG_INTRO_ENABLE = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        MODE_TRACK_ELAPSED   = 2'd0,
        MODE_TRACK_REMAINING = 2'd1,
        MODE_DISC_ELAPSED    = 2'd2,
        MODE_DISC_REMAINING  = 2'd3
    } t_time_mode;

    typedef struct packed {
        t_time_mode time_mode;
        logic       intro_enable;
    } t_config;

    typedef struct packed {
        logic advance;
        logic quick;
        logic minus;
    } t_flags;

endpackage

// ===== rtl/pptd_cfg_regs.sv =====
// Configuration register file of the play position time display.
module pptd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pptd_pkg::REG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output pptd_pkg::t_config                   o_cfg
);

    pptd_pkg::t_time_mode r_time_mode;
    logic                 r_intro_enable;
    pptd_pkg::t_reg_index w_index;

    assign w_index = pptd_pkg::t_reg_index'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_mode    <= pptd_pkg::MODE_TRACK_ELAPSED;
            r_intro_enable <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_index)
                pptd_pkg::REG_TIME_MODE: begin
                    r_time_mode <= pptd_pkg::t_time_mode'(pwdata[1:0]);
                end
                pptd_pkg::REG_INTRO_ENABLE: begin
                    r_intro_enable <= pwdata[0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            pptd_pkg::REG_TIME_MODE:    prdata = {30'd0, r_time_mode};
            pptd_pkg::REG_INTRO_ENABLE: prdata = {31'd0, r_intro_enable};
        endcase
    end

    assign o_cfg.time_mode    = r_time_mode;
    assign o_cfg.intro_enable = r_intro_enable;

endmodule

// ===== rtl/pptd_offset.sv =====
// Track offset, track change and quick update decision, and selection of the shown time.
module pptd_offset #(
    parameter int POSITION_BITS = pptd_pkg::POSITION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  pptd_pkg::t_config        i_cfg,
    input  logic [POSITION_BITS-1:0] i_current_sector,
    input  logic [POSITION_BITS-1:0] i_track_start,
    input  logic [POSITION_BITS-1:0] i_track_length,
    input  logic [POSITION_BITS-1:0] i_time_before_track,
    input  logic [POSITION_BITS-1:0] i_total_time,
    input  logic                     i_reverse,
    output logic                     o_valid,
    output logic [POSITION_BITS:0]   o_time,
    output pptd_pkg::t_flags         o_flags
);

    localparam int N  = POSITION_BITS;
    localparam int TW = POSITION_BITS + 1;

    logic             r_valid;
    logic [TW-1:0]    r_time;
    pptd_pkg::t_flags r_flags;
    logic [TW-1:0]    n_time;
    pptd_pkg::t_flags n_flags;

    always_comb begin
        logic          skipped;
        logic [N-1:0]  rtime;
        logic [TW-1:0] end_pos;
        logic [TW-1:0] before_plus;
        logic [N-1:0]  before_minus;
        logic [N-1:0]  total_m1;
        logic [N-1:0]  len_m1;
        logic [TW-1:0] len_plus;
        logic [TW-1:0] disc_used;

        skipped      = i_current_sector < i_track_start;
        rtime        = skipped ? (i_track_start - i_current_sector)
                               : (i_current_sector - i_track_start);
        end_pos      = {1'b0, i_track_start} + {1'b0, i_track_length};
        before_plus  = {1'b0, i_time_before_track} + {1'b0, rtime};
        before_minus = (i_time_before_track > rtime) ? (i_time_before_track - rtime)
                                                     : N'(0);
        total_m1     = (i_total_time != N'(0)) ? (i_total_time - N'(1)) : N'(0);
        len_m1       = (i_track_length != N'(0)) ? (i_track_length - N'(1)) : N'(0);
        len_plus     = {1'b0, i_track_length} + {1'b0, rtime};
        disc_used    = skipped ? {1'b0, before_minus} : before_plus;

        if (i_reverse) begin
            n_flags.quick   = {1'b0, i_current_sector}
                              <= ({1'b0, i_track_start} + TW'(pptd_pkg::NEAR_END));
            n_flags.advance = !skipped && (rtime == N'(0)) || skipped;
        end else begin
            n_flags.quick   = ({1'b0, i_current_sector} + TW'(pptd_pkg::NEAR_END))
                              >= end_pos;
            n_flags.advance = ({1'b0, i_current_sector} >= end_pos)
                              || (i_cfg.intro_enable && !skipped
                                  && (rtime >= N'(pptd_pkg::INTRO_SECTORS)));
        end

        case (i_cfg.time_mode)
            pptd_pkg::MODE_TRACK_ELAPSED: begin
                n_time        = {1'b0, rtime};
                n_flags.minus = skipped;
            end
            pptd_pkg::MODE_TRACK_REMAINING: begin
                if (skipped) begin
                    n_time = (len_plus != TW'(0)) ? (len_plus - TW'(1)) : TW'(0);
                end else begin
                    n_time = (len_m1 > rtime) ? {1'b0, len_m1 - rtime} : TW'(0);
                end
                n_flags.minus = 1'b1;
            end
            pptd_pkg::MODE_DISC_ELAPSED: begin
                n_time        = disc_used;
                n_flags.minus = 1'b0;
            end
            default: begin
                n_time        = ({1'b0, total_m1} > disc_used)
                                ? ({1'b0, total_m1} - disc_used) : TW'(0);
                n_flags.minus = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_time  <= n_time;
        r_flags <= n_flags;
    end

    assign o_valid = r_valid;
    assign o_time  = r_time;
    assign o_flags = r_flags;

endmodule

// ===== rtl/pptd_time_split.sv =====
// Conversion of a sector count to saturated minutes and seconds, with the result register.
module pptd_time_split #(
    parameter int POSITION_BITS = pptd_pkg::POSITION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [POSITION_BITS:0] i_time,
    input  pptd_pkg::t_flags       i_flags,
    output logic                   o_strobe,
    output logic [7:0]             o_minutes,
    output logic [5:0]             o_seconds,
    output logic                   o_minus,
    output logic                   o_display_valid,
    output logic                   o_advance_track,
    output logic                   o_quick_update
);

    localparam int TW    = POSITION_BITS + 1;
    localparam int SW    = POSITION_BITS - 5;
    localparam int MW    = POSITION_BITS - 10;
    localparam int MXW   = (MW > 8) ? MW : 9;
    localparam int SH75  = 7;
    localparam int SH60  = 6;
    localparam int P1W   = 2 * TW + 1;
    localparam int P2W   = 2 * SW + 1;
    localparam longint SPS = longint'(pptd_pkg::SECTORS_PER_SECOND);
    localparam longint SPM = longint'(pptd_pkg::SECONDS_PER_MINUTE);
    localparam logic [TW:0] M75 = (TW + 1)'(((64'sd1 <<< (TW + SH75)) + SPS - 64'sd1) / SPS);
    localparam logic [SW:0] M60 = (SW + 1)'(((64'sd1 <<< (SW + SH60)) + SPM - 64'sd1) / SPM);

    logic             r_valid_a;
    logic [SW-1:0]    r_secs_a;
    pptd_pkg::t_flags r_flags_a;
    logic             r_valid_b;
    logic [SW-1:0]    r_secs_b;
    logic [MW-1:0]    r_mins_b;
    pptd_pkg::t_flags r_flags_b;
    logic             r_strobe;
    logic [7:0]       r_minutes;
    logic [5:0]       r_seconds;
    logic             r_minus;
    logic             r_display_valid;
    logic             r_advance_track;
    logic             r_quick_update;

    logic [P1W-1:0]   w_prod75;
    logic [P2W-1:0]   w_prod60;
    logic [SW-1:0]    w_whole_secs;
    logic [SW-1:0]    w_rem;
    logic [MXW-1:0]   w_mins_ext;
    logic [7:0]       w_mins_sat;

    assign w_prod75     = P1W'(i_time) * P1W'(M75);
    assign w_prod60     = P2W'(r_secs_a) * P2W'(M60);
    assign w_whole_secs = (SW'(r_mins_b) << 6) - (SW'(r_mins_b) << 2);
    assign w_rem        = r_secs_b - w_whole_secs;
    assign w_mins_ext   = MXW'(r_mins_b);
    assign w_mins_sat   = (w_mins_ext > MXW'(255)) ? 8'd255 : w_mins_ext[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
            r_strobe  <= r_valid_b;
        end
        r_secs_a  <= w_prod75[TW + SH75 +: SW];
        r_flags_a <= i_flags;
        r_mins_b  <= w_prod60[SW + SH60 +: MW];
        r_secs_b  <= r_secs_a;
        r_flags_b <= r_flags_a;
        r_advance_track <= r_flags_b.advance;
        r_quick_update  <= r_flags_b.quick;
        if (r_flags_b.advance) begin
            r_minutes       <= 8'd0;
            r_seconds       <= 6'd0;
            r_minus         <= 1'b0;
            r_display_valid <= 1'b0;
        end else begin
            r_minutes       <= w_mins_sat;
            r_seconds       <= w_rem[5:0];
            r_minus         <= r_flags_b.minus;
            r_display_valid <= 1'b1;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_minutes       = r_minutes;
    assign o_seconds       = r_seconds;
    assign o_minus         = r_minus;
    assign o_display_valid = r_display_valid;
    assign o_advance_track = r_advance_track;
    assign o_quick_update  = r_quick_update;

endmodule

// ===== rtl/play_position_time_display.sv =====
// Top level of the play position time display.
//
// A position transfer is taken at every rising clock edge at which start is
// high and busy is low; busy is always low, so a new position can be given in
// every cycle. The six position fields are captured in an input register.
// A four-register pipeline follows: track offset and time selection, division
// by 75 sectors per second, division by 60 seconds per minute, then the result
// register. Each result is on the o_ ports for exactly one cycle, marked by
// o_strobe; results leave in input order at one per cycle. The receiver
// cannot stall, so no result is held back and nothing is buffered. The
// time mode and intro enable registers are written over the APB-style
// port (byte address 0 and 4); the user must write them only while no
// transfer is in flight, which the block does not enforce. pready is
// always high. A synchronous reset clears the pipeline valid bits and both
// configuration registers, so no strobe follows reset until a new start.
`include "play_position_time_display_defines.svh"

module play_position_time_display #(
    parameter int POSITION_BITS = pptd_pkg::POSITION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pptd_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [POSITION_BITS-1:0]           i_current_sector,
    input  logic [POSITION_BITS-1:0]           i_track_start,
    input  logic [POSITION_BITS-1:0]           i_track_length,
    input  logic [POSITION_BITS-1:0]           i_time_before_track,
    input  logic [POSITION_BITS-1:0]           i_total_time,
    input  logic                               i_reverse,
    output logic                               o_strobe,
    output logic [7:0]                         o_minutes,
    output logic [5:0]                         o_seconds,
    output logic                               o_minus,
    output logic                               o_display_valid,
    output logic                               o_advance_track,
    output logic                               o_quick_update
);

    pptd_pkg::t_config          w_cfg;
    logic                       r_in_valid;
    logic [POSITION_BITS-1:0]   r_current_sector;
    logic [POSITION_BITS-1:0]   r_track_start;
    logic [POSITION_BITS-1:0]   r_track_length;
    logic [POSITION_BITS-1:0]   r_time_before_track;
    logic [POSITION_BITS-1:0]   r_total_time;
    logic                       r_reverse;
    logic                       w_off_valid;
    logic [POSITION_BITS:0]     w_off_time;
    pptd_pkg::t_flags           w_off_flags;
    logic                       w_accept;
    logic                       w_blank_result;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
        if (w_accept) begin
            r_current_sector    <= i_current_sector;
            r_track_start       <= i_track_start;
            r_track_length      <= i_track_length;
            r_time_before_track <= i_time_before_track;
            r_total_time        <= i_total_time;
            r_reverse           <= i_reverse;
        end
    end

    pptd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pptd_offset #(
        .POSITION_BITS (POSITION_BITS)
    ) u_offset (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (r_in_valid),
        .i_cfg               (w_cfg),
        .i_current_sector    (r_current_sector),
        .i_track_start       (r_track_start),
        .i_track_length      (r_track_length),
        .i_time_before_track (r_time_before_track),
        .i_total_time        (r_total_time),
        .i_reverse           (r_reverse),
        .o_valid             (w_off_valid),
        .o_time              (w_off_time),
        .o_flags             (w_off_flags)
    );

    pptd_time_split #(
        .POSITION_BITS (POSITION_BITS)
    ) u_time_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_off_valid),
        .i_time          (w_off_time),
        .i_flags         (w_off_flags),
        .o_strobe        (o_strobe),
        .o_minutes       (o_minutes),
        .o_seconds       (o_seconds),
        .o_minus         (o_minus),
        .o_display_valid (o_display_valid),
        .o_advance_track (o_advance_track),
        .o_quick_update  (o_quick_update)
    );

    assign w_blank_result = !o_display_valid && (o_minutes == 8'd0) && (o_seconds == 6'd0)
                            && !o_minus;

    `PPTD_ASSERT_AFTER(a_latency, i_clk, i_rst_n, w_accept, 5, o_strobe)
    `PPTD_ASSERT_NOW(a_advance_blanks, i_clk, i_rst_n, o_strobe && o_advance_track, w_blank_result)
    `PPTD_ASSERT_NOW(a_seconds_range, i_clk, i_rst_n, o_strobe && o_display_valid, o_seconds < 6'd60)
    `PPTD_ASSERT_NOW(a_valid_or_advance, i_clk, i_rst_n, o_strobe, o_display_valid != o_advance_track)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the play position time display block.
`timescale 1ns / 1ps

module tb_top;
    import pptd_pkg::*;

    localparam int POS_MAX        = (1 << POSITION_BITS) - 1;
    localparam int TIME_MAX       = 452925;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [POSITION_BITS-1:0] sector;
        logic [POSITION_BITS-1:0] tstart;
        logic [POSITION_BITS-1:0] tlen;
        logic [POSITION_BITS-1:0] prior;
        logic [POSITION_BITS-1:0] total;
        logic                     rev;
    } position_t;

    typedef struct {
        logic [7:0] minutes;
        logic [5:0] seconds;
        logic       minus;
        logic       valid;
        logic       advance;
        logic       quick;
    } display_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [REG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     start = 1'b0;
    logic                     busy;
    logic [POSITION_BITS-1:0] i_current_sector = '0;
    logic [POSITION_BITS-1:0] i_track_start = '0;
    logic [POSITION_BITS-1:0] i_track_length = '0;
    logic [POSITION_BITS-1:0] i_time_before_track = '0;
    logic [POSITION_BITS-1:0] i_total_time = '0;
    logic                     i_reverse = 1'b0;
    logic                     o_strobe;
    logic [7:0]               o_minutes;
    logic [5:0]               o_seconds;
    logic                     o_minus;
    logic                     o_display_valid;
    logic                     o_advance_track;
    logic                     o_quick_update;

    t_time_mode cfg_mode = MODE_TRACK_ELAPSED;
    logic       cfg_intro = 1'b0;
    display_t   pending_displays[$];
    int         mismatch_count = 0;
    int         displays_checked = 0;
    int         quiet_cycles = 0;

    play_position_time_display uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .i_current_sector   (i_current_sector),
        .i_track_start      (i_track_start),
        .i_track_length     (i_track_length),
        .i_time_before_track(i_time_before_track),
        .i_total_time       (i_total_time),
        .i_reverse          (i_reverse),
        .o_strobe           (o_strobe),
        .o_minutes          (o_minutes),
        .o_seconds          (o_seconds),
        .o_minus            (o_minus),
        .o_display_valid    (o_display_valid),
        .o_advance_track    (o_advance_track),
        .o_quick_update     (o_quick_update)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned sat_sub(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic display_t predict_display(position_t p);
        display_t        d;
        longint unsigned pos, st, ln, bf, tot, track_end, offset, t, secs, mins;
        bit              back, neg, leave, near;
        pos = p.sector;
        st = p.tstart;
        ln = p.tlen;
        bf = p.prior;
        tot = p.total;
        track_end = st + ln;
        if (pos >= st) begin
            offset = pos - st;
            back = 1'b0;
        end else begin
            offset = st - pos;
            back = 1'b1;
        end
        if (p.rev) begin
            near = pos <= st + NEAR_END;
            leave = pos <= st;
        end else begin
            near = pos + NEAR_END >= track_end;
            leave = pos >= track_end;
            if (cfg_intro && !back && offset >= INTRO_SECTORS) begin
                leave = 1'b1;
            end
        end
        d = '{default: '0};
        d.advance = leave;
        d.quick = near;
        if (!leave) begin
            neg = 1'b0;
            t = 0;
            case (cfg_mode)
                MODE_TRACK_ELAPSED: begin
                    t = offset;
                    neg = back;
                end
                MODE_TRACK_REMAINING: begin
                    t = back ? sat_sub(ln + offset, 1) : sat_sub(sat_sub(ln, 1), offset);
                    neg = 1'b1;
                end
                MODE_DISC_ELAPSED: begin
                    t = back ? sat_sub(bf, offset) : bf + offset;
                end
                MODE_DISC_REMAINING: begin
                    t = back ? sat_sub(sat_sub(tot, 1), sat_sub(bf, offset))
                             : sat_sub(sat_sub(tot, 1), bf + offset);
                    neg = 1'b1;
                end
            endcase
            secs = t / SECTORS_PER_SECOND;
            mins = secs / SECONDS_PER_MINUTE;
            if (mins > 255) begin
                mins = 255;
            end
            d.minutes = mins[7:0];
            d.seconds = 6'(secs % SECONDS_PER_MINUTE);
            d.minus = neg;
            d.valid = 1'b1;
        end
        return d;
    endfunction

    function automatic position_t make_position(int sector, int tstart, int tlen, int prior,
                                                int total, bit rev);
        position_t p;
        p.sector = POSITION_BITS'(sector);
        p.tstart = POSITION_BITS'(tstart);
        p.tlen = POSITION_BITS'(tlen);
        p.prior = POSITION_BITS'(prior);
        p.total = POSITION_BITS'(total);
        p.rev = rev;
        return p;
    endfunction

    function automatic position_t make_random_position();
        int st, ln, off, pos, prior, total;
        bit rev;
        st = $urandom_range(0, POS_MAX);
        case ($urandom_range(0, 4))
            0: ln = $urandom_range(1, 40);
            1: ln = $urandom_range(1, POS_MAX);
            default: ln = $urandom_range(41, 30000);
        endcase
        prior = $urandom_range(0, TIME_MAX);
        total = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TIME_MAX)
                                             : $urandom_range(prior, TIME_MAX);
        rev = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
            0: off = ln - int'($urandom_range(0, 25));
            1: off = $urandom_range(0, 25);
            2: off = INTRO_SECTORS - 3 + int'($urandom_range(0, 5));
            3: off = 0 - int'($urandom_range(1, 2000));
            4: off = ln + int'($urandom_range(0, 50));
            5: begin
                return make_position($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                                     $urandom_range(1, POS_MAX), $urandom_range(0, TIME_MAX),
                                     $urandom_range(0, TIME_MAX), $urandom_range(0, 1));
            end
            default: off = $urandom_range(0, ln);
        endcase
        pos = st + off;
        if (pos < 0) begin
            pos = 0;
        end
        if (pos > POS_MAX) begin
            pos = POS_MAX;
        end
        return make_position(pos, st, ln, prior, total, rev);
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("Mismatch in %s of display %0d: got %0d, expected %0d", field,
                 displays_checked, got, want);
        mismatch_count++;
    endtask

    task automatic send_position(position_t p);
        start <= 1'b1;
        i_current_sector <= p.sector;
        i_track_start <= p.tstart;
        i_track_length <= p.tlen;
        i_time_before_track <= p.prior;
        i_total_time <= p.total;
        i_reverse <= p.rev;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_displays.push_back(predict_display(p));
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        i_current_sector <= POSITION_BITS'($urandom);
        i_track_start <= POSITION_BITS'($urandom);
        i_reverse <= $urandom_range(0, 1);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_displays.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(t_reg_index idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_TIME_MODE: cfg_mode = t_time_mode'(value[1:0]);
            REG_INTRO_ENABLE: cfg_intro = value[0];
        endcase
    endtask

    task automatic set_config(t_time_mode mode, logic intro);
        wait_for_results();
        write_register(REG_TIME_MODE, 32'(mode));
        write_register(REG_INTRO_ENABLE, 32'(intro));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_track_elapsed_edges();
        set_config(MODE_TRACK_ELAPSED, 1'b0);
        send_position(make_position(0, 0, 0, 0, 0, 1'b0));
        send_position(make_position(1000, 1000, 5000, 300, 9000, 1'b0));
        send_position(make_position(5979, 1000, 5000, 300, 9000, 1'b0));
        send_position(make_position(5980, 1000, 5000, 300, 9000, 1'b0));
        send_position(make_position(5999, 1000, 5000, 300, 9000, 1'b0));
        send_position(make_position(6000, 1000, 5000, 300, 9000, 1'b0));
        send_position(make_position(70, 70, 10, 0, 100, 1'b0));
        send_position(make_position(0, POS_MAX, POS_MAX, TIME_MAX, TIME_MAX, 1'b0));
        send_position(make_position(POS_MAX, 0, POS_MAX, TIME_MAX, TIME_MAX, 1'b0));
    endtask

    task automatic test_reverse_play();
        send_position(make_position(4000, 4000, 800, 10, 5000, 1'b1));
        send_position(make_position(4020, 4000, 800, 10, 5000, 1'b1));
        send_position(make_position(4021, 4000, 800, 10, 5000, 1'b1));
        send_position(make_position(3000, 4000, 800, 10, 5000, 1'b1));
    endtask

    task automatic test_intro_mode();
        set_config(MODE_TRACK_ELAPSED, 1'b1);
        send_position(make_position(2748, 2000, 9000, 0, 20000, 1'b0));
        send_position(make_position(2749, 2000, 9000, 0, 20000, 1'b0));
        send_position(make_position(500, 2000, 9000, 0, 20000, 1'b0));
        send_position(make_position(2800, 2000, 9000, 0, 20000, 1'b1));
    endtask

    task automatic test_remaining_and_disc_modes();
        set_config(MODE_TRACK_REMAINING, 1'b0);
        send_position(make_position(9100, 8000, 1000, 0, 50000, 1'b1));
        send_position(make_position(7500, 8000, 1000, 0, 50000, 1'b0));
        set_config(MODE_DISC_ELAPSED, 1'b0);
        send_position(make_position(7900, 8000, 1000, 10, 50000, 1'b0));
        send_position(make_position(8500, 8000, 1000, 30000, 50000, 1'b0));
        set_config(MODE_DISC_REMAINING, 1'b1);
        send_position(make_position(8100, 8000, 1000, 0, 0, 1'b0));
        send_position(make_position(8600, 8000, 1000, 30000, 30200, 1'b0));
        send_position(make_position(7000, 8000, 2000, 40000, TIME_MAX, 1'b0));
    endtask

    task automatic test_random_positions();
        bit idle_on;
        for (int phase = 0; phase < 8; phase++) begin
            set_config(t_time_mode'(phase % 4), phase >= 4);
            idle_on = (phase != 7) && ($urandom_range(0, 4) != 0);
            for (int n = 0; n < 200; n++) begin
                send_position(make_random_position());
                if (phase == 2 && n == 100) begin
                    wait_for_results();
                end else if (idle_on && $urandom_range(0, 3) == 0) begin
                    idle_cycles($urandom_range(1, 18));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        display_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_displays.size() == 0) begin
                report_mismatch("strobe", 1, 0);
            end else begin
                want = pending_displays.pop_front();
                if (o_minutes !== want.minutes) report_mismatch("minutes", o_minutes, want.minutes);
                if (o_seconds !== want.seconds) report_mismatch("seconds", o_seconds, want.seconds);
                if (o_minus !== want.minus) report_mismatch("minus", o_minus, want.minus);
                if (o_display_valid !== want.valid) begin
                    report_mismatch("display_valid", o_display_valid, want.valid);
                end
                if (o_advance_track !== want.advance) begin
                    report_mismatch("advance_track", o_advance_track, want.advance);
                end
                if (o_quick_update !== want.quick) begin
                    report_mismatch("quick_update", o_quick_update, want.quick);
                end
                displays_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_track_elapsed_edges();
        test_reverse_play();
        test_intro_mode();
        test_remaining_and_disc_modes();
        test_random_positions();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_displays.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
